// ----- rtl/fcc_pkg.sv -----
// Shared types, constants and divider step functions for the floor and ceiling caster.
`default_nettype none
package fcc_pkg;

    localparam int TEX_SIDE_W     = 64;
    localparam int TEX_SIDE_H     = 64;
    localparam int MAX_SCREEN_DIM = 2048;

    localparam int TEX_AW    = 12;
    localparam int TEX_DEPTH = 1 << TEX_AW;
    localparam int COLOR_W   = 32;
    localparam int COORD_W   = 11;
    localparam int DIM_W     = 12;
    localparam int FIX_W     = 32;
    localparam int FRAC_W    = 16;
    localparam int CFG_IDX_W = 3;

    localparam int SIDE_CW = $clog2(TEX_SIDE_W + 1) > $clog2(TEX_SIDE_H + 1)
                           ? $clog2(TEX_SIDE_W + 1) : $clog2(TEX_SIDE_H + 1);
    localparam int TX_W    = $clog2(TEX_SIDE_W);
    localparam int TY_W    = $clog2(TEX_SIDE_H);

    localparam int DIST_DW = COORD_W;
    localparam int DIST_NW = DIM_W + 15;
    localparam int OFS_DW  = DIM_W;
    localparam int OFS_NW  = 54;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CAM_POS_X   = 3'd0,
        REG_CAM_POS_Y   = 3'd1,
        REG_VIEW_DIR_X  = 3'd2,
        REG_VIEW_DIR_Y  = 3'd3,
        REG_PLANE_X     = 3'd4,
        REG_PLANE_Y     = 3'd5,
        REG_SCR_WIDTH   = 3'd6,
        REG_SCR_HEIGHT  = 3'd7
    } t_reg_idx;

    typedef enum logic {
        MODE_LOAD   = 1'b0,
        MODE_RENDER = 1'b1
    } t_mode;

    typedef struct packed {
        logic                 mode;
        logic                 texture_select;
        logic [TEX_AW-1:0]    texel_index;
        logic [COLOR_W-1:0]   texel_color;
        logic [COORD_W-1:0]   pixel_column;
        logic [COORD_W-1:0]   pixel_row;
    } t_in_item;

    typedef struct packed {
        logic [COORD_W-1:0]   out_column;
        logic [COORD_W-1:0]   floor_row;
        logic [COORD_W-1:0]   ceiling_row;
        logic [COLOR_W-1:0]   floor_color;
        logic [COLOR_W-1:0]   ceiling_color;
        logic                 bad_pixel;
    } t_out_item;

    typedef struct packed {
        logic                 mode;
        logic                 sel;
        logic [TEX_AW-1:0]    idx;
        logic [COLOR_W-1:0]   color;
        logic [COORD_W-1:0]   col;
        logic [COORD_W-1:0]   row;
        logic [COORD_W-1:0]   crow;
        logic                 bad;
    } t_side;

    typedef struct packed {
        logic [FIX_W-1:0] pos_x;
        logic [FIX_W-1:0] pos_y;
        logic [FIX_W-1:0] dir_x;
        logic [FIX_W-1:0] dir_y;
        logic [FIX_W-1:0] pl_x;
        logic [FIX_W-1:0] pl_y;
        logic [DIM_W-1:0] width;
        logic [DIM_W-1:0] height;
    } t_cfg;

    function automatic logic [DIST_DW+DIST_NW-1:0] dist_step(
        input logic [DIST_DW+DIST_NW-1:0] r,
        input logic [DIST_DW-1:0]         d
    );
        logic [DIST_DW+DIST_NW:0] t;
        logic [DIST_DW:0]         top;
        t   = {r, 1'b0};
        top = t[DIST_DW+DIST_NW:DIST_NW];
        if (top >= {1'b0, d}) begin
            top  = top - {1'b0, d};
            t[0] = 1'b1;
        end
        return {top[DIST_DW-1:0], t[DIST_NW-1:0]};
    endfunction

    function automatic logic [OFS_DW+OFS_NW-1:0] ofs_step(
        input logic [OFS_DW+OFS_NW-1:0] r,
        input logic [OFS_DW-1:0]        d
    );
        logic [OFS_DW+OFS_NW:0] t;
        logic [OFS_DW:0]        top;
        t   = {r, 1'b0};
        top = t[OFS_DW+OFS_NW:OFS_NW];
        if (top >= {1'b0, d}) begin
            top  = top - {1'b0, d};
            t[0] = 1'b1;
        end
        return {top[OFS_DW-1:0], t[OFS_NW-1:0]};
    endfunction

endpackage
`default_nettype wire

// ----- rtl/fcc_dist.sv -----
// Pixel checks and the pipelined row distance divider.
`default_nettype none
module fcc_dist (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_adv,
    input  wire logic             i_valid,
    input  wire fcc_pkg::t_in_item i_item,
    input  wire fcc_pkg::t_cfg    i_cfg,
    output logic                  o_valid,
    output fcc_pkg::t_side        o_sb,
    output logic [fcc_pkg::DIST_NW-1:0] o_dist
);

    localparam int NW = fcc_pkg::DIST_NW;
    localparam int DW = fcc_pkg::DIST_DW;
    localparam int RW = NW + DW;

    logic [fcc_pkg::COORD_W-1:0] half;
    logic [DW-1:0]               den;
    logic [NW-1:0]               num;
    fcc_pkg::t_side              sb_in;

    logic                r_v   [0:NW];
    fcc_pkg::t_side      r_sb  [0:NW];
    logic [RW-1:0]       r_div [0:NW];
    logic [DW-1:0]       r_den [0:NW];

    always_comb begin
        half = i_cfg.height[fcc_pkg::DIM_W-1:1];
        den  = DW'(i_item.pixel_row - half);
        num  = {i_cfg.height, 15'b0};
        sb_in.mode  = i_item.mode;
        sb_in.sel   = i_item.texture_select;
        sb_in.idx   = i_item.texel_index;
        sb_in.color = i_item.texel_color;
        sb_in.col   = i_item.pixel_column;
        sb_in.row   = i_item.pixel_row;
        sb_in.crow  = fcc_pkg::COORD_W'(i_cfg.height - fcc_pkg::DIM_W'(1)
                      - {1'b0, i_item.pixel_row});
        sb_in.bad   = (int'(i_cfg.width) > fcc_pkg::MAX_SCREEN_DIM)
                   || (int'(i_cfg.height) > fcc_pkg::MAX_SCREEN_DIM)
                   || ({1'b0, i_item.pixel_column} >= i_cfg.width)
                   || ({1'b0, i_item.pixel_row} >= i_cfg.height)
                   || (i_item.pixel_row <= half);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_adv) begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_sb[0]  <= sb_in;
            r_div[0] <= {{DW{1'b0}}, num};
            r_den[0] <= den;
        end
    end

    for (genvar s = 1; s <= NW; s++) begin : g_stage
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s] <= 1'b0;
            end else if (i_adv) begin
                r_v[s] <= r_v[s-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                r_sb[s]  <= r_sb[s-1];
                r_div[s] <= fcc_pkg::dist_step(r_div[s-1], r_den[s-1]);
                r_den[s] <= r_den[s-1];
            end
        end
    end

    assign o_valid = r_v[NW];
    assign o_sb    = r_sb[NW];
    assign o_dist  = r_div[NW][NW-1:0];

endmodule
`default_nettype wire

// ----- rtl/fcc_world.sv -----
// World position pipeline: products, column offset divider and texel address.
`default_nettype none
module fcc_world (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_adv,
    input  wire logic                   i_valid,
    input  wire fcc_pkg::t_side         i_sb,
    input  wire logic [fcc_pkg::DIST_NW-1:0] i_dist,
    input  wire fcc_pkg::t_cfg          i_cfg,
    output logic                        o_valid,
    output fcc_pkg::t_side              o_sb,
    output logic [fcc_pkg::TEX_AW-1:0]  o_addr
);

    localparam int FW    = fcc_pkg::FIX_W;
    localparam int FRW   = fcc_pkg::FRAC_W;
    localparam int DST_W = fcc_pkg::DIST_NW;
    localparam int PLO_W = DST_W + FRW;
    localparam int PHI_W = DST_W + 1 + (FW + 1 - FRW);
    localparam int SPL_W = 23;
    localparam int NLO_W = fcc_pkg::COORD_W + SPL_W;
    localparam int NHI_W = fcc_pkg::COORD_W + 1 + (PHI_W - SPL_W);
    localparam int N_W   = NHI_W + SPL_W;
    localparam int NW    = fcc_pkg::OFS_NW;
    localparam int DW    = fcc_pkg::OFS_DW;
    localparam int RW    = NW + DW;
    localparam int PXW   = FRW + fcc_pkg::SIDE_CW;

    // Stage 0: distance products.
    logic signed [FW:0]    dir0_x, dir0_y;
    logic [FW:0]           pl2_x, pl2_y;
    logic [FW-1:0]         bprod_x, bprod_y;
    logic [PLO_W-1:0]      plo_x, plo_y;
    logic signed [PHI_W-1:0] phi_x, phi_y;

    logic                  r_s0_v;
    fcc_pkg::t_side        r_s0_sb;
    logic [FRW-1:0]        r_s0_bx, r_s0_by;
    logic [PLO_W-1:0]      r_s0_plox, r_s0_ploy;
    logic signed [PHI_W-1:0] r_s0_phix, r_s0_phiy;

    always_comb begin
        dir0_x  = $signed({i_cfg.dir_x[FW-1], i_cfg.dir_x})
                - $signed({i_cfg.pl_x[FW-1], i_cfg.pl_x});
        dir0_y  = $signed({i_cfg.dir_y[FW-1], i_cfg.dir_y})
                - $signed({i_cfg.pl_y[FW-1], i_cfg.pl_y});
        pl2_x   = {i_cfg.pl_x, 1'b0};
        pl2_y   = {i_cfg.pl_y, 1'b0};
        bprod_x = FW'(i_dist) * dir0_x[FW-1:0];
        bprod_y = FW'(i_dist) * dir0_y[FW-1:0];
        plo_x   = PLO_W'(i_dist) * PLO_W'(pl2_x[FRW-1:0]);
        plo_y   = PLO_W'(i_dist) * PLO_W'(pl2_y[FRW-1:0]);
        phi_x   = $signed({1'b0, i_dist}) * $signed(pl2_x[FW:FRW]);
        phi_y   = $signed({1'b0, i_dist}) * $signed(pl2_y[FW:FRW]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_v <= 1'b0;
        end else if (i_adv) begin
            r_s0_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_s0_sb   <= i_sb;
            r_s0_bx   <= bprod_x[FW-1:FRW];
            r_s0_by   <= bprod_y[FW-1:FRW];
            r_s0_plox <= plo_x;
            r_s0_ploy <= plo_y;
            r_s0_phix <= phi_x;
            r_s0_phiy <= phi_y;
        end
    end

    // Stage 1: spread per screen width.
    logic                    r_s1_v;
    fcc_pkg::t_side          r_s1_sb;
    logic [FRW-1:0]          r_s1_bx, r_s1_by;
    logic signed [PHI_W-1:0] r_s1_sx, r_s1_sy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (i_adv) begin
            r_s1_v <= r_s0_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_s1_sb <= r_s0_sb;
            r_s1_bx <= r_s0_bx;
            r_s1_by <= r_s0_by;
            r_s1_sx <= r_s0_phix + $signed(PHI_W'(r_s0_plox[PLO_W-1:FRW]));
            r_s1_sy <= r_s0_phiy + $signed(PHI_W'(r_s0_ploy[PLO_W-1:FRW]));
        end
    end

    // Stage 2: column times spread, in two partial products.
    logic [NLO_W-1:0]        nlo_x, nlo_y;
    logic signed [NHI_W-1:0] nhi_x, nhi_y;

    logic                    r_s2_v;
    fcc_pkg::t_side          r_s2_sb;
    logic [FRW-1:0]          r_s2_bx, r_s2_by;
    logic [NLO_W-1:0]        r_s2_nlox, r_s2_nloy;
    logic signed [NHI_W-1:0] r_s2_nhix, r_s2_nhiy;

    always_comb begin
        nlo_x = NLO_W'(r_s1_sb.col) * NLO_W'(r_s1_sx[SPL_W-1:0]);
        nlo_y = NLO_W'(r_s1_sb.col) * NLO_W'(r_s1_sy[SPL_W-1:0]);
        nhi_x = $signed({1'b0, r_s1_sb.col}) * $signed(r_s1_sx[PHI_W-1:SPL_W]);
        nhi_y = $signed({1'b0, r_s1_sb.col}) * $signed(r_s1_sy[PHI_W-1:SPL_W]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v <= 1'b0;
        end else if (i_adv) begin
            r_s2_v <= r_s1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_s2_sb   <= r_s1_sb;
            r_s2_bx   <= r_s1_bx;
            r_s2_by   <= r_s1_by;
            r_s2_nlox <= nlo_x;
            r_s2_nloy <= nlo_y;
            r_s2_nhix <= nhi_x;
            r_s2_nhiy <= nhi_y;
        end
    end

    // Stage 3 feeds the offset divider with the magnitude of a floor division.
    logic [N_W-1:0] num_x, num_y;
    logic [N_W-1:0] mag_x, mag_y;

    always_comb begin
        num_x = {r_s2_nhix, {SPL_W{1'b0}}} + {{(N_W-NLO_W){1'b0}}, r_s2_nlox};
        num_y = {r_s2_nhiy, {SPL_W{1'b0}}} + {{(N_W-NLO_W){1'b0}}, r_s2_nloy};
        mag_x = num_x[N_W-1] ? ~num_x : num_x;
        mag_y = num_y[N_W-1] ? ~num_y : num_y;
    end

    logic            r_dv  [0:NW];
    fcc_pkg::t_side  r_dsb [0:NW];
    logic [FRW-1:0]  r_dbx [0:NW];
    logic [FRW-1:0]  r_dby [0:NW];
    logic            r_dnx [0:NW];
    logic            r_dny [0:NW];
    logic [RW-1:0]   r_dx  [0:NW];
    logic [RW-1:0]   r_dy  [0:NW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv[0] <= 1'b0;
        end else if (i_adv) begin
            r_dv[0] <= r_s2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_dsb[0] <= r_s2_sb;
            r_dbx[0] <= r_s2_bx;
            r_dby[0] <= r_s2_by;
            r_dnx[0] <= num_x[N_W-1];
            r_dny[0] <= num_y[N_W-1];
            r_dx[0]  <= {{DW{1'b0}}, mag_x[NW-1:0]};
            r_dy[0]  <= {{DW{1'b0}}, mag_y[NW-1:0]};
        end
    end

    for (genvar s = 1; s <= NW; s++) begin : g_div
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv[s] <= 1'b0;
            end else if (i_adv) begin
                r_dv[s] <= r_dv[s-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                r_dsb[s] <= r_dsb[s-1];
                r_dbx[s] <= r_dbx[s-1];
                r_dby[s] <= r_dby[s-1];
                r_dnx[s] <= r_dnx[s-1];
                r_dny[s] <= r_dny[s-1];
                r_dx[s]  <= fcc_pkg::ofs_step(r_dx[s-1], i_cfg.width);
                r_dy[s]  <= fcc_pkg::ofs_step(r_dy[s-1], i_cfg.width);
            end
        end
    end

    // Fractional world position.
    logic [FRW-1:0] off_x, off_y;
    logic           r_wa_v;
    fcc_pkg::t_side r_wa_sb;
    logic [FRW-1:0] r_wa_x, r_wa_y;

    always_comb begin
        off_x = r_dnx[NW] ? ~r_dx[NW][FRW-1:0] : r_dx[NW][FRW-1:0];
        off_y = r_dny[NW] ? ~r_dy[NW][FRW-1:0] : r_dy[NW][FRW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wa_v <= 1'b0;
        end else if (i_adv) begin
            r_wa_v <= r_dv[NW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_wa_sb <= r_dsb[NW];
            r_wa_x  <= i_cfg.pos_x[FRW-1:0] + r_dbx[NW] + off_x;
            r_wa_y  <= i_cfg.pos_y[FRW-1:0] + r_dby[NW] + off_y;
        end
    end

    // Texture coordinates.
    logic [PXW-1:0]             prod_tx, prod_ty;
    logic                       r_wb_v;
    fcc_pkg::t_side             r_wb_sb;
    logic [fcc_pkg::TX_W-1:0]   r_wb_tx;
    logic [fcc_pkg::TY_W-1:0]   r_wb_ty;

    always_comb begin
        prod_tx = PXW'(r_wa_x) * PXW'(fcc_pkg::TEX_SIDE_W);
        prod_ty = PXW'(r_wa_y) * PXW'(fcc_pkg::TEX_SIDE_H);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wb_v <= 1'b0;
        end else if (i_adv) begin
            r_wb_v <= r_wa_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_wb_sb <= r_wa_sb;
            r_wb_tx <= prod_tx[FRW +: fcc_pkg::TX_W];
            r_wb_ty <= prod_ty[FRW +: fcc_pkg::TY_W];
        end
    end

    // Texel address; a load uses its own index.
    logic [fcc_pkg::TEX_AW-1:0] tex_addr;
    logic                       r_wc_v;
    fcc_pkg::t_side             r_wc_sb;
    logic [fcc_pkg::TEX_AW-1:0] r_wc_addr;

    always_comb begin
        tex_addr = fcc_pkg::TEX_AW'(int'(r_wb_ty) * fcc_pkg::TEX_SIDE_W + int'(r_wb_tx));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wc_v <= 1'b0;
        end else if (i_adv) begin
            r_wc_v <= r_wb_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_wc_sb   <= r_wb_sb;
            r_wc_addr <= (r_wb_sb.mode == fcc_pkg::MODE_RENDER) ? tex_addr : r_wb_sb.idx;
        end
    end

    assign o_valid = r_wc_v;
    assign o_sb    = r_wc_sb;
    assign o_addr  = r_wc_addr;

endmodule
`default_nettype wire

// ----- rtl/fcc_tex.sv -----
// Floor and ceiling texture memories with the result register.
`default_nettype none
module fcc_tex (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_adv,
    input  wire logic                       i_valid,
    input  wire fcc_pkg::t_side             i_sb,
    input  wire logic [fcc_pkg::TEX_AW-1:0] i_addr,
    output logic                            o_valid,
    output fcc_pkg::t_out_item              o_item
);

    logic [fcc_pkg::COLOR_W-1:0] r_floor_mem [0:fcc_pkg::TEX_DEPTH-1];
    logic [fcc_pkg::COLOR_W-1:0] r_ceil_mem  [0:fcc_pkg::TEX_DEPTH-1];
    logic [fcc_pkg::COLOR_W-1:0] r_floor_q, r_ceil_q;
    logic                        r_v;
    fcc_pkg::t_side              r_sb;
    logic                        load_en;

    assign load_en = i_valid && (i_sb.mode == fcc_pkg::MODE_LOAD);

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            if (load_en && !i_sb.sel) begin
                r_floor_mem[i_addr] <= i_sb.color;
            end
            r_floor_q <= r_floor_mem[i_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            if (load_en && i_sb.sel) begin
                r_ceil_mem[i_addr] <= i_sb.color;
            end
            r_ceil_q <= r_ceil_mem[i_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (i_adv) begin
            r_v <= i_valid && (i_sb.mode == fcc_pkg::MODE_RENDER);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_sb <= i_sb;
        end
    end

    always_comb begin
        o_item.out_column    = r_sb.col;
        o_item.floor_row     = r_sb.row;
        o_item.ceiling_row   = r_sb.bad ? '0 : r_sb.crow;
        o_item.floor_color   = r_sb.bad ? '0 : r_floor_q;
        o_item.ceiling_color = r_sb.bad ? '0 : r_ceil_q;
        o_item.bad_pixel     = r_sb.bad;
    end

    assign o_valid = r_v;

endmodule
`default_nettype wire

// ----- rtl/floor_ceiling_texture_caster.sv -----
// Top level of the floor and ceiling texture caster.
// One request enters per clock, loads and renders alike, as long as the result side does
// not stall; each render passes the bit-per-stage row distance and column offset dividers.
// Loads travel the same pipeline and write the texture memories at the stage where renders
// read them, so every render sees exactly the texels loaded before it. A stall on the result
// side freezes the whole pipeline while a result is valid. Configuration is to be written
// by the user only while the block is idle; the block itself does not enforce this.
`default_nettype none
module floor_ceiling_texture_caster (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_stall,
    input  wire fcc_pkg::t_in_item                 i_in_data,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_stall,
    output fcc_pkg::t_out_item                     o_out_data,
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [fcc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [fcc_pkg::FIX_W-1:0]         i_cfg_data
);

    fcc_pkg::t_cfg  r_cfg;
    logic           adv;
    logic           dist_valid;
    fcc_pkg::t_side dist_sb;
    logic [fcc_pkg::DIST_NW-1:0] dist_val;
    logic           world_valid;
    fcc_pkg::t_side world_sb;
    logic [fcc_pkg::TEX_AW-1:0]  world_addr;

    assign o_cfg_ready = 1'b1;
    assign adv         = !(o_out_valid && i_out_stall);
    assign o_in_stall  = !adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pos_x  <= '0;
            r_cfg.pos_y  <= '0;
            r_cfg.dir_x  <= 32'd65536;
            r_cfg.dir_y  <= '0;
            r_cfg.pl_x   <= '0;
            r_cfg.pl_y   <= 32'd43254;
            r_cfg.width  <= 12'd640;
            r_cfg.height <= 12'd480;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (fcc_pkg::t_reg_idx'(i_cfg_index))
                fcc_pkg::REG_CAM_POS_X:  r_cfg.pos_x  <= i_cfg_data;
                fcc_pkg::REG_CAM_POS_Y:  r_cfg.pos_y  <= i_cfg_data;
                fcc_pkg::REG_VIEW_DIR_X: r_cfg.dir_x  <= i_cfg_data;
                fcc_pkg::REG_VIEW_DIR_Y: r_cfg.dir_y  <= i_cfg_data;
                fcc_pkg::REG_PLANE_X:    r_cfg.pl_x   <= i_cfg_data;
                fcc_pkg::REG_PLANE_Y:    r_cfg.pl_y   <= i_cfg_data;
                fcc_pkg::REG_SCR_WIDTH:  r_cfg.width  <= i_cfg_data[fcc_pkg::DIM_W-1:0];
                fcc_pkg::REG_SCR_HEIGHT: r_cfg.height <= i_cfg_data[fcc_pkg::DIM_W-1:0];
                default: ;
            endcase
        end
    end

    fcc_dist u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_valid (i_in_valid),
        .i_item  (i_in_data),
        .i_cfg   (r_cfg),
        .o_valid (dist_valid),
        .o_sb    (dist_sb),
        .o_dist  (dist_val)
    );

    fcc_world u_world (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_valid (dist_valid),
        .i_sb    (dist_sb),
        .i_dist  (dist_val),
        .i_cfg   (r_cfg),
        .o_valid (world_valid),
        .o_sb    (world_sb),
        .o_addr  (world_addr)
    );

    fcc_tex u_tex (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_valid (world_valid),
        .i_sb    (world_sb),
        .i_addr  (world_addr),
        .o_valid (o_out_valid),
        .o_item  (o_out_data)
    );

endmodule
`default_nettype wire
